// ===== rtl/core/decr_pkg.sv =====
// Package for the dual encoder count and rate block.
// Holds widths, item kind codes, register indexes and the rate scale.
// No dependencies.
package decr_pkg;

    localparam int CountW = 32;
    localparam int ScaleW = 10;
    localparam int NumW   = 41;
    localparam int StepW  = 6;

    localparam logic [ScaleW-1:0] RateScale = 10'd1000;
    localparam logic [StepW-1:0]  DivSteps  = 6'(NumW);

    localparam logic [1:0] KIND_EDGE   = 2'd0;
    localparam logic [1:0] KIND_SAMPLE = 2'd1;
    localparam logic [1:0] KIND_CLEAR  = 2'd2;

    localparam logic CFG_LEFT_REVERSE  = 1'b0;
    localparam logic CFG_RIGHT_REVERSE = 1'b1;

    localparam logic WHEEL_LEFT  = 1'b0;
    localparam logic WHEEL_RIGHT = 1'b1;

    typedef struct packed {
        logic             start;
        logic [NumW-1:0]  dividend;
        logic [CountW-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic            done;
        logic [NumW-1:0] quotient;
    } t_div_rsp;

endpackage

// ===== rtl/core/dual_encoder_count_and_rate.sv =====
// Top level of the two-wheel encoder count and rate block.
// Depends on decr_pkg and decr_div.
//
//   channel | valid      | stall       | payload
//   --------+------------+-------------+----------------------------------------
//   in      | i_in_valid | o_in_stall  | i_kind i_wheel i_pin_a i_pin_b i_time_ms
//   out     | o_out_valid| i_out_stall | o_left_count o_right_count o_left_rate
//           |            |             | o_right_rate
//   cfg     | i_cfg_we   | -           | i_cfg_index i_cfg_data
//
// Edge, clear and unused-kind items have their result registered at acceptance.
// A sample item goes per wheel through a multiply state, the shared divider and
// saturation in the cycle the divider is done, two wheels in turn, then an output
// state. The next item is taken in the cycle after the output at the earliest.
// Reset is synchronous; it clears counts, snapshots, rates and the result valid.
// The block takes no item while a sample is in work or a result is stalled.
module dual_encoder_count_and_rate (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic [1:0]                        i_kind,
    input  logic                              i_wheel,
    input  logic                              i_pin_a,
    input  logic                              i_pin_b,
    input  logic [decr_pkg::CountW-1:0]       i_time_ms,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic signed [decr_pkg::CountW-1:0] o_left_count,
    output logic signed [decr_pkg::CountW-1:0] o_right_count,
    output logic signed [decr_pkg::CountW-1:0] o_left_rate,
    output logic signed [decr_pkg::CountW-1:0] o_right_rate,
    input  logic                              i_cfg_we,
    input  logic                              i_cfg_index,
    input  logic                              i_cfg_data
);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_MUL  = 4'b0010,
        S_DIV  = 4'b0100,
        S_OUT  = 4'b1000
    } t_state;

    localparam int W = decr_pkg::CountW;
    localparam int N = decr_pkg::NumW;

    t_state          r_state, n_state;
    logic            r_left_rev, r_right_rev;
    logic [W-1:0]    r_left_ticks, n_left_ticks;
    logic [W-1:0]    r_right_ticks, n_right_ticks;
    logic [W-1:0]    r_left_snap, r_right_snap;
    logic [W-1:0]    r_last_time;
    logic [W-1:0]    r_left_speed, n_left_speed;
    logic [W-1:0]    r_right_speed, n_right_speed;
    logic [W-1:0]    r_delta_l, r_delta_r, r_elapsed;
    logic            r_sel, n_sel;
    logic            r_neg, n_neg;
    logic            r_out_valid, n_out_valid;
    logic [W-1:0]    r_out_lc, r_out_rc, r_out_lr, r_out_rr;
    logic            load_out;
    logic            accept;
    logic            out_busy;
    logic            fwd;
    logic [W-1:0]    delta;
    logic [W-1:0]    mag;
    logic [W+decr_pkg::ScaleW-1:0] product;
    logic [W-1:0]    sat;
    logic [N-1:0]    q;
    decr_pkg::t_div_req div_req;
    decr_pkg::t_div_rsp div_rsp;

    decr_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    assign out_busy   = r_out_valid && i_out_stall;
    assign o_in_stall = (r_state != S_IDLE) || out_busy;
    assign accept     = i_in_valid && !o_in_stall;

    always_comb begin
        delta   = r_sel ? r_delta_r : r_delta_l;
        mag     = delta[W-1] ? (~delta + 1'b1) : delta;
        product = mag * decr_pkg::RateScale;
        div_req.start    = (r_state == S_MUL);
        div_req.dividend = product[N-1:0];
        div_req.divisor  = r_elapsed;
        q = div_rsp.quotient;
        if (r_elapsed == '0) begin
            sat = '0;
        end else if (r_neg) begin
            if (q > N'({1'b1, {(W-1){1'b0}}})) begin
                sat = {1'b1, {(W-1){1'b0}}};
            end else begin
                sat = ~q[W-1:0] + 1'b1;
            end
        end else begin
            if (q > N'({1'b0, {(W-1){1'b1}}})) begin
                sat = {1'b0, {(W-1){1'b1}}};
            end else begin
                sat = q[W-1:0];
            end
        end
    end

    always_comb begin
        n_state       = r_state;
        n_left_ticks  = r_left_ticks;
        n_right_ticks = r_right_ticks;
        n_left_speed  = r_left_speed;
        n_right_speed = r_right_speed;
        n_sel         = r_sel;
        n_neg         = r_neg;
        n_out_valid   = r_out_valid && i_out_stall;
        load_out      = 1'b0;
        fwd           = (i_pin_a == i_pin_b) ^ (i_wheel ? r_right_rev : r_left_rev);
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    case (i_kind)
                        decr_pkg::KIND_EDGE: begin
                            if (i_wheel == decr_pkg::WHEEL_RIGHT) begin
                                n_right_ticks = fwd ? r_right_ticks + 1'b1
                                                    : r_right_ticks - 1'b1;
                            end else begin
                                n_left_ticks = fwd ? r_left_ticks + 1'b1
                                                   : r_left_ticks - 1'b1;
                            end
                            load_out = 1'b1;
                        end
                        decr_pkg::KIND_SAMPLE: begin
                            n_sel   = decr_pkg::WHEEL_LEFT;
                            n_state = S_MUL;
                        end
                        decr_pkg::KIND_CLEAR: begin
                            n_left_ticks  = '0;
                            n_right_ticks = '0;
                            load_out      = 1'b1;
                        end
                        default: begin
                            load_out = 1'b1;
                        end
                    endcase
                end
            end
            S_MUL: begin
                n_neg   = delta[W-1];
                n_state = S_DIV;
            end
            S_DIV: begin
                if (div_rsp.done) begin
                    if (r_sel == decr_pkg::WHEEL_RIGHT) begin
                        n_right_speed = sat;
                        n_state       = S_OUT;
                    end else begin
                        n_left_speed = sat;
                        n_sel        = decr_pkg::WHEEL_RIGHT;
                        n_state      = S_MUL;
                    end
                end
            end
            S_OUT: begin
                if (!out_busy) begin
                    load_out = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        if (load_out) begin
            n_out_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_left_rev    <= 1'b0;
            r_right_rev   <= 1'b1;
            r_left_ticks  <= '0;
            r_right_ticks <= '0;
            r_left_snap   <= '0;
            r_right_snap  <= '0;
            r_last_time   <= '0;
            r_left_speed  <= '0;
            r_right_speed <= '0;
            r_out_valid   <= 1'b0;
            r_sel         <= 1'b0;
            r_neg         <= 1'b0;
        end else begin
            r_state       <= n_state;
            r_left_ticks  <= n_left_ticks;
            r_right_ticks <= n_right_ticks;
            r_left_speed  <= n_left_speed;
            r_right_speed <= n_right_speed;
            r_out_valid   <= n_out_valid;
            r_sel         <= n_sel;
            r_neg         <= n_neg;
            if (i_cfg_we) begin
                case (i_cfg_index)
                    decr_pkg::CFG_LEFT_REVERSE:  r_left_rev  <= i_cfg_data;
                    decr_pkg::CFG_RIGHT_REVERSE: r_right_rev <= i_cfg_data;
                    default: ;
                endcase
            end
            if (accept && (i_kind == decr_pkg::KIND_SAMPLE)) begin
                r_left_snap  <= r_left_ticks;
                r_right_snap <= r_right_ticks;
                r_last_time  <= i_time_ms;
            end
        end
        if (accept && (i_kind == decr_pkg::KIND_SAMPLE)) begin
            r_delta_l <= r_left_ticks - r_left_snap;
            r_delta_r <= r_right_ticks - r_right_snap;
            r_elapsed <= i_time_ms - r_last_time;
        end
        if (load_out) begin
            r_out_lc <= n_left_ticks;
            r_out_rc <= n_right_ticks;
            r_out_lr <= n_left_speed;
            r_out_rr <= n_right_speed;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_left_count  = r_out_lc;
    assign o_right_count = r_out_rc;
    assign o_left_rate   = r_out_lr;
    assign o_right_rate  = r_out_rr;

endmodule

// ===== rtl/core/decr_div.sv =====
// Shared restoring divider, one quotient bit per cycle.
// Depends on decr_pkg for widths and the request and response structs.
module decr_div (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  decr_pkg::t_div_req  i_req,
    output decr_pkg::t_div_rsp  o_rsp
);

    logic                          r_busy, n_busy;
    logic                          r_done, n_done;
    logic [decr_pkg::StepW-1:0]    r_cnt, n_cnt;
    logic [decr_pkg::CountW-1:0]   r_rem, n_rem;
    logic [decr_pkg::NumW-1:0]     r_quo, n_quo;
    logic [decr_pkg::CountW-1:0]   r_den, n_den;
    logic [decr_pkg::CountW:0]     shifted;
    logic [decr_pkg::CountW+1:0]   diff;
    logic                          ge;

    always_comb begin
        shifted = {r_rem, r_quo[decr_pkg::NumW-1]};
        diff    = {1'b0, shifted} - {2'b00, r_den};
        ge      = !diff[decr_pkg::CountW+1];
        n_busy  = r_busy;
        n_done  = 1'b0;
        n_cnt   = r_cnt;
        n_rem   = r_rem;
        n_quo   = r_quo;
        n_den   = r_den;
        if (i_req.start) begin
            n_busy = 1'b1;
            n_cnt  = decr_pkg::DivSteps;
            n_rem  = '0;
            n_quo  = i_req.dividend;
            n_den  = i_req.divisor;
        end else if (r_busy) begin
            n_rem = ge ? diff[decr_pkg::CountW-1:0] : shifted[decr_pkg::CountW-1:0];
            n_quo = {r_quo[decr_pkg::NumW-2:0], ge};
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == decr_pkg::StepW'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_rem <= n_rem;
        r_quo <= n_quo;
        r_den <= n_den;
    end

    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_quo;

endmodule
